[hdl/grid_ray_cast_wall_slice_macros.svh]
// Assertion macros for the grid ray caster modules.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef GRID_RAY_CAST_WALL_SLICE_MACROS_SVH
`define GRID_RAY_CAST_WALL_SLICE_MACROS_SVH

// property checked on every clock edge outside reset
`define GRCWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// consequence required in the cycle after the antecedent
`define GRCWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/grcws_pkg.sv]
// Shared types and constants of the grid ray caster.
// No dependencies; used by every module of the block.
`default_nettype none
package grcws_pkg;
	localparam int IN_W  = 56;
	localparam int OUT_W = 48;
	localparam int DVD_W = 40;
	localparam int DSR_W = 31;

	localparam logic [11:0] ANG_QUARTER = 12'd1024;
	localparam logic [11:0] ANG_HALF    = 12'd2048;
	localparam logic [11:0] ANG_3QUART  = 12'd3072;

	localparam logic [17:0] POLY_A = 18'd102939;
	localparam logic [17:0] POLY_B = 18'd42155;
	localparam logic [17:0] POLY_C = 18'd4765;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	localparam logic [16:0] DIST_MAX   = 17'd131071;
	localparam logic [15:0] HEIGHT_MAX = 16'd65535;
	localparam logic [8:0]  WALL_MAX_H = 9'd480;
	localparam logic [9:0]  VIEW_ROWS  = 10'd512;
	// 480*480*128*16384
	localparam logic [DVD_W-1:0] HGT_NUM = 40'd483183820800;
	localparam logic [16:0] TILE = 17'd8192;

	localparam logic [2:0] FACE_DOWN  = 3'd0;
	localparam logic [2:0] FACE_UP    = 3'd1;
	localparam logic [2:0] FACE_RIGHT = 3'd2;
	localparam logic [2:0] FACE_LEFT  = 3'd3;
	localparam logic [2:0] FACE_NONE  = 3'd4;

	// trig polynomial steps
	localparam logic [2:0] TSTEP_X   = 3'd0;
	localparam logic [2:0] TSTEP_SQ  = 3'd1;
	localparam logic [2:0] TSTEP_C   = 3'd2;
	localparam logic [2:0] TSTEP_B   = 3'd3;
	localparam logic [2:0] TSTEP_OUT = 3'd4;

	typedef enum logic [1:0] {TS_SIN_A, TS_COS_A, TS_COS_V} trig_sel_t;
	typedef enum logic [1:0] {DK_OFF, DK_STEP, DK_LEN, DK_HGT} div_kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TRIG, S_WINIT, S_WCHK, S_WOFF, S_WSDIV, S_WSTEP, S_WLEN,
		S_PICK, S_FIN, S_HDIV, S_EMIT
	} state_t;

	typedef struct packed {
		logic      load;
		logic      trig_en;
		logic [2:0] trig_step;
		trig_sel_t trig_sel;
		logic      walk_init;
		logic      walk_horiz;
		logic      walk_adv;
		logic      div_start;
		div_kind_t div_kind;
		logic      pick;
		logic      emit;
	} cmd_t;

	typedef struct packed {
		logic walk_ok;
		logic hit;
		logic div_busy;
		logic div_done;
		logic face_none;
		logic hgt_sat;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

[hdl/grcws_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses grcws_pkg for widths.
`default_nettype none
module grcws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [grcws_pkg::DVD_W-1:0] dividend,
	input  logic [grcws_pkg::DSR_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [grcws_pkg::DVD_W-1:0] quot,
	output logic [grcws_pkg::DSR_W-1:0] rem
);
	import grcws_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q, dsr_q;
	logic [DSR_W:0]   trial, diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

[hdl/grcws_dp.sv]
// Datapath: trig evaluation, boundary walk, result selection, output register.
// Uses grcws_pkg and instantiates grcws_div.
`default_nettype none
module grcws_dp #(
	parameter int MAP_COLS = 8,
	parameter int MAP_ROWS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  grcws_pkg::cmd_t             cmd,
	output grcws_pkg::sts_t             sts,
	input  logic [grcws_pkg::IN_W-1:0]  in_data,
	input  logic                        cfg_we,
	input  logic [63:0]                 cfg_wdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [grcws_pkg::OUT_W-1:0] m_tdata
);
	import grcws_pkg::*;

	// item registers
	logic [15:0] px_q, py_q;
	logic [11:0] ang_q, voff_q;
	logic [63:0] wall_q;

	// trig
	logic signed [15:0] sin_q, cos_q, fc_q;
	logic [16:0] x_q, x2_q;
	logic [17:0] t_q;
	logic        neg_q;
	logic [11:0] trig_ang;
	logic [10:0] rr;
	logic [17:0] mul_a, mul_b;
	logic [35:0] prod;
	logic [17:0] tq;
	logic [16:0] tr;
	logic [14:0] tcap;
	logic signed [15:0] tval;

	// walk
	logic        horiz_q, fwd_q, tn_neg_q, axis_ok_q;
	logic [14:0] mag_m_q, mag_n_q, rem_q, stprem_q;
	logic [15:0] pn_q;
	logic [16:0] d_q;
	logic [31:0] off_q;
	logic [27:0] stp_q;
	logic signed [4:0] check_q;

	// init mux
	logic [15:0] pm_i, pn_i;
	logic signed [15:0] tm_i, tn_i;
	logic        fwd_i, axis_i;

	// hit test
	logic signed [33:0] n_s;
	logic        n_in, c_in, hit;
	logic [2:0]  ncell, cidx, row, col;
	logic [15:0] rsum;
	logic        cy;

	// results
	logic [30:0] hlen_q, vlen_q, lenp;
	logic        hval_q, vval_q, hbet;
	logic [16:0] dist_q;
	logic [2:0]  face_q;
	logic [15:0] height_q;
	logic [8:0]  hclamp;
	logic [9:0]  topw;

	// divider
	div_kind_t        kind_q;
	logic [DVD_W-1:0] dvd, quot;
	logic [DSR_W-1:0] dsr, drem;
	logic             div_busy, div_done;

	// output register
	logic        m_tvalid_q;
	logic [16:0] o_dist_q;
	logic [2:0]  o_face_q;
	logic [15:0] o_height_q;
	logic [8:0]  o_top_q;

	// ---- trig ----
	always_comb begin
		unique case (cmd.trig_sel)
			TS_SIN_A: trig_ang = ang_q;
			TS_COS_A: trig_ang = ang_q + ANG_QUARTER;
			default:  trig_ang = voff_q + ANG_QUARTER;
		endcase
	end
	assign rr = trig_ang[10] ? 11'd1024 - {1'b0, trig_ang[9:0]} : {1'b0, trig_ang[9:0]};

	always_comb begin
		if (cmd.trig_en) begin
			unique case (cmd.trig_step)
				TSTEP_SQ: begin mul_a = {1'b0, x_q};  mul_b = {1'b0, x_q};  end
				TSTEP_C:  begin mul_a = POLY_C;       mul_b = {1'b0, x2_q}; end
				TSTEP_B:  begin mul_a = t_q;          mul_b = {1'b0, x2_q}; end
				default:  begin mul_a = t_q;          mul_b = {1'b0, x_q};  end
			endcase
		end else if (cmd.div_kind == DK_HGT) begin
			mul_a = {1'b0, dist_q};
			mul_b = {3'b0, fc_q[14:0]};
		end else begin
			mul_a = {1'b0, d_q};
			mul_b = {3'b0, mag_n_q};
		end
	end
	assign prod = {18'b0, mul_a} * {18'b0, mul_b};

	assign tq   = 18'(prod[35:16]);
	assign tr   = 17'((tq + 18'd2) >> 2);
	assign tcap = (tr > {2'b0, ONE_Q14}) ? ONE_Q14 : tr[14:0];
	assign tval = neg_q ? -$signed({1'b0, tcap}) : $signed({1'b0, tcap});

	// ---- walk setup ----
	always_comb begin
		if (cmd.walk_horiz) begin
			pm_i   = py_q;
			pn_i   = px_q;
			tm_i   = sin_q;
			tn_i   = cos_q;
			fwd_i  = ang_q < ANG_HALF;
			axis_i = (ang_q != 12'd0) && (ang_q != ANG_HALF);
		end else begin
			pm_i   = px_q;
			pn_i   = py_q;
			tm_i   = cos_q;
			tn_i   = sin_q;
			fwd_i  = (ang_q < ANG_QUARTER) || (ang_q > ANG_3QUART);
			axis_i = (ang_q != ANG_QUARTER) && (ang_q != ANG_3QUART);
		end
	end

	// ---- hit test on the current crossing ----
	assign n_s = tn_neg_q ? $signed({18'b0, pn_q}) - $signed({2'b0, off_q})
	                      : $signed({18'b0, pn_q}) + $signed({2'b0, off_q});
	assign ncell = n_s[15:13];
	assign n_in  = !n_s[33] &&
		(n_s[32:13] < (horiz_q ? 20'(MAP_COLS) : 20'(MAP_ROWS)));
	assign c_in  = !check_q[4] &&
		(check_q[3:0] < (horiz_q ? 4'(MAP_ROWS) : 4'(MAP_COLS)));
	assign cidx  = check_q[2:0];
	assign row   = horiz_q ? cidx : ncell;
	assign col   = horiz_q ? ncell : cidx;
	assign hit   = !(n_in && c_in) || wall_q[{row, col}];

	assign rsum = {1'b0, rem_q} + {1'b0, stprem_q};
	assign cy   = rsum >= {1'b0, mag_m_q};

	// ---- divider ----
	always_comb begin
		unique case (cmd.div_kind)
			DK_OFF:  begin dvd = DVD_W'(prod);              dsr = DSR_W'(mag_m_q); end
			DK_STEP: begin dvd = DVD_W'({mag_n_q, 13'b0});  dsr = DSR_W'(mag_m_q); end
			DK_LEN:  begin dvd = DVD_W'({d_q, 14'b0});      dsr = DSR_W'(mag_m_q); end
			default: begin dvd = HGT_NUM;                   dsr = DSR_W'(prod);    end
		endcase
	end

	grcws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot),
		.rem      (drem)
	);

	// ---- result pick ----
	assign hbet = hval_q && (!vval_q || (hlen_q < vlen_q));
	assign lenp = hbet ? hlen_q : vlen_q;

	assign hclamp = (height_q > {7'b0, WALL_MAX_H}) ? WALL_MAX_H : height_q[8:0];
	assign topw   = VIEW_ROWS - {1'b0, hclamp};

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_q     <= '0;
			m_tvalid_q <= 1'b0;
			hval_q     <= 1'b0;
			vval_q     <= 1'b0;
		end else begin
			if (cfg_we)
				wall_q <= cfg_wdata;
			if (cmd.emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (cmd.load) begin
				hval_q <= 1'b0;
				vval_q <= 1'b0;
			end else if (div_done && kind_q == DK_LEN) begin
				if (horiz_q)
					hval_q <= 1'b1;
				else
					vval_q <= 1'b1;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= in_data[15:0];
			py_q   <= in_data[31:16];
			ang_q  <= in_data[43:32];
			voff_q <= in_data[55:44];
		end

		if (cmd.trig_en) begin
			unique case (cmd.trig_step)
				TSTEP_X: begin
					x_q   <= {rr, 6'b0};
					neg_q <= trig_ang[11];
				end
				TSTEP_SQ: x2_q <= prod[32:16];
				TSTEP_C:  t_q  <= POLY_B - 18'(prod[35:16]);
				TSTEP_B:  t_q  <= POLY_A - 18'(prod[35:16]);
				default: begin
					unique case (cmd.trig_sel)
						TS_SIN_A: sin_q <= tval;
						TS_COS_A: cos_q <= tval;
						default:  fc_q  <= tval;
					endcase
				end
			endcase
		end

		if (cmd.walk_init) begin
			horiz_q   <= cmd.walk_horiz;
			fwd_q     <= fwd_i;
			axis_ok_q <= axis_i;
			tn_neg_q  <= tn_i[15];
			mag_m_q   <= tm_i[15] ? 15'(-tm_i) : tm_i[14:0];
			mag_n_q   <= tn_i[15] ? 15'(-tn_i) : tn_i[14:0];
			pn_q      <= pn_i;
			d_q       <= fwd_i ? TILE - {4'b0, pm_i[12:0]} : {4'b0, pm_i[12:0]};
			check_q   <= fwd_i ? $signed({2'b0, pm_i[15:13]}) + 5'sd1
			                   : $signed({2'b0, pm_i[15:13]}) - 5'sd1;
		end else if (cmd.walk_adv) begin
			d_q     <= d_q + TILE;
			rem_q   <= cy ? 15'(rsum - {1'b0, mag_m_q}) : rsum[14:0];
			off_q   <= off_q + {4'b0, stp_q} + {31'b0, cy};
			check_q <= fwd_q ? check_q + 5'sd1 : check_q - 5'sd1;
		end

		if (cmd.div_start)
			kind_q <= cmd.div_kind;

		if (div_done) begin
			unique case (kind_q)
				DK_OFF: begin
					off_q <= quot[31:0];
					rem_q <= drem[14:0];
				end
				DK_STEP: begin
					stp_q    <= quot[27:0];
					stprem_q <= drem[14:0];
				end
				DK_LEN: begin
					if (horiz_q)
						hlen_q <= quot[30:0];
					else
						vlen_q <= quot[30:0];
				end
				default: height_q <= (|quot[DVD_W-1:16]) ? HEIGHT_MAX : quot[15:0];
			endcase
		end

		if (cmd.pick) begin
			if (hbet) begin
				face_q <= (ang_q < ANG_HALF) ? FACE_DOWN : FACE_UP;
			end else if (vval_q) begin
				face_q <= ((ang_q < ANG_QUARTER) || (ang_q > ANG_3QUART)) ?
					FACE_RIGHT : FACE_LEFT;
			end else begin
				face_q <= FACE_NONE;
			end
			if (!hval_q && !vval_q) begin
				dist_q   <= DIST_MAX;
				height_q <= '0;
			end else begin
				dist_q   <= (lenp > {14'b0, DIST_MAX}) ? DIST_MAX : lenp[16:0];
				height_q <= HEIGHT_MAX;
			end
		end

		if (cmd.emit) begin
			o_dist_q   <= dist_q;
			o_face_q   <= face_q;
			o_height_q <= height_q;
			o_top_q    <= topw[9:1];
		end
	end

	// ---- status ----
	always_comb begin
		sts.walk_ok   = axis_ok_q && (mag_m_q != '0);
		sts.hit       = hit;
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.face_none = face_q == FACE_NONE;
		sts.hgt_sat   = (dist_q == '0) || fc_q[15] || (fc_q == '0);
		sts.out_free  = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b0, o_top_q, o_height_q, o_face_q, o_dist_q};
endmodule
`default_nettype wire

[hdl/grcws_ctrl.sv]
// Controller state machine sequencing trig, both walks and the slice divide.
// Uses grcws_pkg and the assertion macros header.
`default_nettype none
`include "grid_ray_cast_wall_slice_macros.svh"
module grcws_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output grcws_pkg::cmd_t cmd,
	input  grcws_pkg::sts_t sts
);
	import grcws_pkg::*;

	state_t    state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	trig_sel_t sel_q, sel_d;
	logic      vert_q, vert_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= TSTEP_X;
			sel_q   <= TS_SIN_A;
			vert_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			vert_q  <= vert_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		sel_d          = sel_q;
		vert_d         = vert_q;
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.trig_step  = cnt_q;
		cmd.trig_sel   = sel_q;
		cmd.walk_horiz = !vert_q;
		cmd.div_kind   = DK_OFF;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = TSTEP_X;
					sel_d    = TS_SIN_A;
					vert_d   = 1'b0;
					state_d  = S_TRIG;
				end
			end
			S_TRIG: begin
				cmd.trig_en = 1'b1;
				if (cnt_q == TSTEP_OUT) begin
					cnt_d = TSTEP_X;
					unique case (sel_q)
						TS_SIN_A: sel_d = TS_COS_A;
						TS_COS_A: sel_d = TS_COS_V;
						default:  state_d = S_WINIT;
					endcase
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			S_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = S_WCHK;
			end
			S_WCHK: begin
				if (sts.walk_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_kind  = DK_OFF;
					state_d       = S_WOFF;
				end else if (!vert_q) begin
					vert_d  = 1'b1;
					state_d = S_WINIT;
				end else begin
					state_d = S_PICK;
				end
			end
			S_WOFF: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_kind  = DK_STEP;
					state_d       = S_WSDIV;
				end
			end
			S_WSDIV: begin
				if (sts.div_done)
					state_d = S_WSTEP;
			end
			S_WSTEP: begin
				if (sts.hit) begin
					cmd.div_start = 1'b1;
					cmd.div_kind  = DK_LEN;
					state_d       = S_WLEN;
				end else begin
					cmd.walk_adv = 1'b1;
				end
			end
			S_WLEN: begin
				if (sts.div_done) begin
					if (!vert_q) begin
						vert_d  = 1'b1;
						state_d = S_WINIT;
					end else begin
						state_d = S_PICK;
					end
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (!sts.face_none && !sts.hgt_sat) begin
					cmd.div_start = 1'b1;
					cmd.div_kind  = DK_HGT;
					state_d       = S_HDIV;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_HDIV: begin
				cmd.div_kind = DK_HGT;
				if (sts.div_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`GRCWS_ASSERT(a_div_idle_on_start, cmd.div_start |-> !sts.div_busy, "divider restarted while busy")
	`GRCWS_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")
	`GRCWS_ASSERT(a_emit_free, cmd.emit |-> sts.out_free, "result overwrote pending transfer")
endmodule
`default_nettype wire

[hdl/grid_ray_cast_wall_slice.sv]
// Grid ray caster, top level: stream ports, wall map register, controller
// and datapath. Depends on grcws_pkg, grcws_ctrl, grcws_dp (with grcws_div).
//
// Casts one ray per input transfer against an 8x8 wall bitmap with 64-unit
// tiles and returns one result transfer: distance to the nearest wall
// crossing (1/128 units, 131071 = none or saturated), the face that was hit,
// the fish-eye corrected wall slice height and its top row on a 512-row
// view. Horizontal and vertical tile boundaries are walked in turn, one
// boundary per cycle, with the cross-axis offset carried incrementally as a
// quotient and remainder. Sine and cosine come from a Q2.14 odd polynomial
// evaluated in five steps on one shared 18x18 multiplier. Every quotient
// goes through one radix-2 divider. Items are processed one at a time:
// load and trig, per walk three divides and the boundaries visited (at most
// 8), then pick, the slice divide and the output register load, so the
// time per ray is bounded by the divider. An axis-aligned walk skips its
// divides. The next ray is accepted while the previous result still waits
// in the output register. The user must write wall_map with cfg_we and
// cfg_wdata (bit row*8+col, 1 = wall) only while no ray is in flight; the
// block itself does not enforce this.
`default_nettype none
module grid_ray_cast_wall_slice #(
	parameter int MAP_COLS = 8,
	parameter int MAP_ROWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input ray
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // pos_x[15:0], pos_y[31:16], ray_angle[43:32],
	                               // view_offset_angle[55:44]
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // distance[16:0], hit_face[19:17],
	                               // slice_height[35:20], slice_top[44:36], zero[47:45]
	// wall map register
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import grcws_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: trig, two walks, slice divide, emit
	grcws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// all arithmetic, the wall map and the output register
	grcws_dp #(
		.MAP_COLS (MAP_COLS),
		.MAP_ROWS (MAP_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);
endmodule
`default_nettype wire
